// ===== rtl/pidtc_pkg.sv =====
// Package: shared types, widths and codes for the clamped trapezoid PID core.
`timescale 1ns / 1ps
`default_nettype none
package pidtc_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int MAG_W         = DATA_WIDTH + 1;
    localparam int PROD_W        = 2 * MAG_W;
    localparam int DIV_BITS      = MAG_W + FRACTION_BITS;
    localparam int CNT_W         = $clog2(DIV_BITS + 1);
    localparam int ADDR_W        = 5;
    localparam int IDX_W         = 3;

    // largest positive value, 2^(W-1)-1
    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

    // operation codes
    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_INTEG_LIMIT  = 3'd3,
        REG_OUTPUT_LIMIT = 3'd4,
        REG_ABS_MODE     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                          operation;
        logic signed [DATA_WIDTH-1:0]  error_value;
        logic        [DATA_WIDTH-1:0]  timestamp;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  drive;
        logic                          zero_interval;
    } t_out_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  prop_gain;
        logic signed [DATA_WIDTH-1:0]  integ_gain;
        logic signed [DATA_WIDTH-1:0]  deriv_gain;
        logic        [DATA_WIDTH-2:0]  integ_limit;
        logic        [DATA_WIDTH-2:0]  output_limit;
        logic                          abs_mode;
    } t_cfg;

    // multiplier operand pair / saturation target
    typedef enum logic [1:0] {
        MUL_INC = 2'd0,
        MUL_P   = 2'd1,
        MUL_I   = 2'd2,
        MUL_D   = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     restart;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sat_en;
        t_mul_sel sat_sel;
        logic     div_init;
        logic     div_step;
        logic     div_fin;
        logic     out_load;
    } t_ctrl;

    typedef struct packed {
        logic zero_dt;
        logic out_free;
    } t_stat;

    // magnitude of a signed value one bit wider than the data
    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
        logic [MAG_W-1:0] r;
        r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pidtc_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module pidtc_regs
    import pidtc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg          r_cfg;
    logic [IDX_W-1:0] w_idx;
    logic          w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= 32'sd65536;
            r_cfg.integ_gain   <= 32'sd65536;
            r_cfg.deriv_gain   <= 32'sd65536;
            r_cfg.integ_limit  <= VMAX[DATA_WIDTH-2:0];
            r_cfg.output_limit <= VMAX[DATA_WIDTH-2:0];
            r_cfg.abs_mode     <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PROP_GAIN:    r_cfg.prop_gain    <= pwdata;
                REG_INTEG_GAIN:   r_cfg.integ_gain   <= pwdata;
                REG_DERIV_GAIN:   r_cfg.deriv_gain   <= pwdata;
                REG_INTEG_LIMIT:  r_cfg.integ_limit  <= pwdata[DATA_WIDTH-2:0];
                REG_OUTPUT_LIMIT: r_cfg.output_limit <= pwdata[DATA_WIDTH-2:0];
                REG_ABS_MODE:     r_cfg.abs_mode     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_PROP_GAIN:    prdata = r_cfg.prop_gain;
            REG_INTEG_GAIN:   prdata = r_cfg.integ_gain;
            REG_DERIV_GAIN:   prdata = r_cfg.deriv_gain;
            REG_INTEG_LIMIT:  prdata = {1'b0, r_cfg.integ_limit};
            REG_OUTPUT_LIMIT: prdata = {1'b0, r_cfg.output_limit};
            REG_ABS_MODE:     prdata = {31'd0, r_cfg.abs_mode};
            default:          prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/pidtc_ctrl.sv =====
// Sequencer: steps the datapath through one compute word.
`timescale 1ns / 1ps
`default_nettype none
module pidtc_ctrl
    import pidtc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_operation,
    input  t_stat     i_stat,
    output logic      o_in_ready,
    output t_ctrl     o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE, S_INC_MUL, S_INC_SAT, S_P_MUL, S_P_SAT, S_I_MUL, S_I_SAT,
        S_DIV_INIT, S_DIV, S_DIV_FIN, S_D_MUL, S_D_SAT, S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctrl  = '0;
        o_ctrl.mul_sel = MUL_INC;
        o_ctrl.sat_sel = MUL_INC;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_operation == OP_RESTART) begin
                        o_ctrl.restart = 1'b1;
                    end else begin
                        o_ctrl.load = 1'b1;
                        n_state = S_INC_MUL;
                    end
                end
            end
            S_INC_MUL: begin
                o_ctrl.mul_en = 1'b1; o_ctrl.mul_sel = MUL_INC; n_state = S_INC_SAT;
            end
            S_INC_SAT: begin
                o_ctrl.sat_en = 1'b1; o_ctrl.sat_sel = MUL_INC; n_state = S_P_MUL;
            end
            S_P_MUL: begin
                o_ctrl.mul_en = 1'b1; o_ctrl.mul_sel = MUL_P; n_state = S_P_SAT;
            end
            S_P_SAT: begin
                o_ctrl.sat_en = 1'b1; o_ctrl.sat_sel = MUL_P; n_state = S_I_MUL;
            end
            S_I_MUL: begin
                o_ctrl.mul_en = 1'b1; o_ctrl.mul_sel = MUL_I; n_state = S_I_SAT;
            end
            S_I_SAT: begin
                o_ctrl.sat_en = 1'b1; o_ctrl.sat_sel = MUL_I;
                // zero interval leaves the derivative at zero
                n_state = i_stat.zero_dt ? S_D_MUL : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_ctrl.div_init = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_ctrl.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                o_ctrl.div_fin = 1'b1; n_state = S_D_MUL;
            end
            S_D_MUL: begin
                o_ctrl.mul_en = 1'b1; o_ctrl.mul_sel = MUL_D; n_state = S_D_SAT;
            end
            S_D_SAT: begin
                o_ctrl.sat_en = 1'b1; o_ctrl.sat_sel = MUL_D; n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pidtc_dp.sv =====
// Datapath: state, shared multiplier, saturation, serial divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module pidtc_dp
    import pidtc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_ctrl     i_ctrl,
    input  t_cfg      i_cfg,
    input  t_in_word  i_in_word,
    input  wire logic i_out_ready,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int SUM_W = DATA_WIDTH + 3;

    // controller state
    logic        [DATA_WIDTH-1:0] r_prev_time;
    logic signed [DATA_WIDTH-1:0] r_integ;
    logic signed [DATA_WIDTH-1:0] r_prev_err;
    // per-word working registers
    logic signed [DATA_WIDTH-1:0] r_e;
    logic        [DATA_WIDTH-1:0] r_dt;
    logic                         r_zero;
    logic signed [MAG_W-1:0]      r_s;
    logic                         r_dnum_neg;
    logic        [MAG_W-1:0]      r_dnum_mag;
    logic        [PROD_W-1:0]     r_prod;
    logic                         r_neg;
    logic signed [DATA_WIDTH-1:0] r_pt, r_it, r_dterm, r_deriv;
    logic        [DATA_WIDTH-1:0] r_rem;
    logic        [DIV_BITS-1:0]   r_dq;
    logic                         r_out_valid;
    t_out_word                    r_out_word;

    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out_word;
    assign o_stat.zero_dt  = r_zero;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // load-time sums
    logic signed [MAG_W-1:0] w_e33, w_pe33;
    assign w_e33  = {i_in_word.error_value[DATA_WIDTH-1], i_in_word.error_value};
    assign w_pe33 = {r_prev_err[DATA_WIDTH-1], r_prev_err};

    // multiplier operand select
    logic [MAG_W-1:0]  w_a, w_b;
    logic              w_neg;
    logic [PROD_W-1:0] w_prod;
    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_INC: begin
                w_a = mag(r_s); w_b = {1'b0, r_dt}; w_neg = r_s[MAG_W-1];
            end
            MUL_P: begin
                w_a   = mag({i_cfg.prop_gain[DATA_WIDTH-1], i_cfg.prop_gain});
                w_b   = mag({r_e[DATA_WIDTH-1], r_e});
                w_neg = i_cfg.prop_gain[DATA_WIDTH-1] ^ r_e[DATA_WIDTH-1];
            end
            MUL_I: begin
                w_a   = mag({i_cfg.integ_gain[DATA_WIDTH-1], i_cfg.integ_gain});
                w_b   = mag({r_integ[DATA_WIDTH-1], r_integ});
                w_neg = i_cfg.integ_gain[DATA_WIDTH-1] ^ r_integ[DATA_WIDTH-1];
            end
            default: begin
                w_a   = mag({i_cfg.deriv_gain[DATA_WIDTH-1], i_cfg.deriv_gain});
                w_b   = mag({r_deriv[DATA_WIDTH-1], r_deriv});
                w_neg = i_cfg.deriv_gain[DATA_WIDTH-1] ^ r_deriv[DATA_WIDTH-1];
            end
        endcase
    end
    assign w_prod = w_a * w_b;

    // shift and saturate the registered product
    logic [PROD_W-1:0]       w_shift, w_lim;
    logic [MAG_W-1:0]        w_sat_mag;
    logic signed [MAG_W:0]   w_sat;
    always_comb begin
        if (i_ctrl.sat_sel == MUL_INC) begin
            w_shift = r_prod >> (FRACTION_BITS + 1);
            w_lim   = PROD_W'(1) << DATA_WIDTH;
        end else begin
            w_shift = r_prod >> FRACTION_BITS;
            w_lim   = PROD_W'(VMAX);
        end
        w_sat_mag = (w_shift > w_lim) ? w_lim[MAG_W-1:0] : w_shift[MAG_W-1:0];
        w_sat     = r_neg ? -$signed({1'b0, w_sat_mag}) : $signed({1'b0, w_sat_mag});
    end

    // integral accumulate and clamp
    logic signed [SUM_W-1:0] w_isum, w_ilim, w_iclamp;
    always_comb begin
        w_isum = SUM_W'(r_integ) + SUM_W'(w_sat);
        w_ilim = $signed({4'd0, i_cfg.integ_limit});
        if (w_isum > w_ilim)       w_iclamp = w_ilim;
        else if (w_isum < -w_ilim) w_iclamp = -w_ilim;
        else                       w_iclamp = w_isum;
    end

    // divider step
    logic [DATA_WIDTH:0] w_trial;
    logic                w_ge;
    assign w_trial = {r_rem, r_dq[DIV_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dt});

    // divider result
    logic [DATA_WIDTH-1:0] w_q;
    assign w_q = (r_dq > DIV_BITS'(VMAX)) ? VMAX : r_dq[DATA_WIDTH-1:0];

    // final sum: abs-mode limit, add, clamp
    logic [MAG_W-1:0]        w_mp, w_md, w_mmin;
    logic signed [SUM_W-1:0] w_d, w_u, w_olim, w_uclamp;
    always_comb begin
        w_mp   = mag({r_pt[DATA_WIDTH-1], r_pt});
        w_md   = mag({r_dterm[DATA_WIDTH-1], r_dterm});
        w_mmin = (w_mp < w_md) ? w_mp : w_md;
        if (i_cfg.abs_mode) begin
            w_d = r_deriv[DATA_WIDTH-1] ? -$signed(SUM_W'(w_mmin)) : $signed(SUM_W'(w_mmin));
        end else begin
            w_d = SUM_W'(r_dterm);
        end
        w_u    = SUM_W'(r_pt) + SUM_W'(r_it) + w_d;
        w_olim = $signed({4'd0, i_cfg.output_limit});
        if (w_u > w_olim)       w_uclamp = w_olim;
        else if (w_u < -w_olim) w_uclamp = -w_olim;
        else                    w_uclamp = w_u;
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_integ     <= '0;
            r_prev_err  <= '0;
        end else if (i_ctrl.restart) begin
            r_prev_time <= i_in_word.timestamp;
            r_integ     <= '0;
            r_prev_err  <= '0;
        end else if (i_ctrl.load) begin
            r_prev_time <= i_in_word.timestamp;
            r_prev_err  <= i_in_word.error_value;
        end else if (i_ctrl.sat_en && i_ctrl.sat_sel == MUL_INC) begin
            r_integ <= w_iclamp[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_e        <= i_in_word.error_value;
            r_dt       <= i_in_word.timestamp - r_prev_time;
            r_zero     <= (i_in_word.timestamp == r_prev_time);
            r_s        <= w_e33 + w_pe33;
            r_dnum_neg <= (w_e33 < w_pe33);
            r_dnum_mag <= mag(w_e33 - w_pe33);
            r_deriv    <= '0;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
            r_neg  <= w_neg;
        end
        if (i_ctrl.sat_en) begin
            case (i_ctrl.sat_sel)
                MUL_P:   r_pt    <= w_sat[DATA_WIDTH-1:0];
                MUL_I:   r_it    <= w_sat[DATA_WIDTH-1:0];
                MUL_D:   r_dterm <= w_sat[DATA_WIDTH-1:0];
                default: ;
            endcase
        end
        if (i_ctrl.div_init) begin
            r_rem <= '0;
            r_dq  <= {r_dnum_mag, {FRACTION_BITS{1'b0}}};
        end else if (i_ctrl.div_step) begin
            r_rem <= w_ge ? DATA_WIDTH'(w_trial - {1'b0, r_dt}) : w_trial[DATA_WIDTH-1:0];
            r_dq  <= {r_dq[DIV_BITS-2:0], w_ge};
        end
        if (i_ctrl.div_fin) begin
            r_deriv <= r_dnum_neg ? -$signed(w_q) : $signed(w_q);
        end
        if (i_ctrl.out_load) begin
            r_out_word.drive         <= w_uclamp[DATA_WIDTH-1:0];
            r_out_word.zero_interval <= r_zero;
        end
    end

    // output word handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pid_trapezoid_clamped_core.sv =====
// Top level of the clamped trapezoid PID core.
// Signed Q16.16 PID step with trapezoidal integral, integral and output clamps and an
// optional derivative-magnitude limit. A compute word passes through one shared 33x33
// multiplier four times, plus a 49-step one-bit-per-cycle divider for the derivative
// that is skipped when the time step is zero. The next word is accepted in the cycle
// after the result is loaded, so compute words do not overlap. The result load stalls
// while the previous result still waits. A restart word is absorbed while the core
// stays idle and gives no result. The result sits in an output register, so the next
// word is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module pid_trapezoid_clamped_core
    import pidtc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  t_in_word               i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_word              o_out_word,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_cfg  w_cfg;
    t_ctrl w_ctrl;
    t_stat w_stat;

    pidtc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pidtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_word.operation),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_ctrl      (w_ctrl)
    );

    pidtc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg       (w_cfg),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

// ===== sim/pidtc_checker.sv =====
// Checker for the clamped trapezoid PID core: predicts each result and compares it.
`timescale 1ns / 1ps
module pidtc_checker
    import pidtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_word          i_in_word,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_word         i_out_word,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    localparam longint SAT_MAX  = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint INC_MAX  = longint'(1) << DATA_WIDTH;

    // shadow of the control registers
    longint kp, ki, kd, integ_lim, out_lim;
    bit     abs_lim;

    // controller state
    logic [DATA_WIDTH-1:0] last_stamp;
    longint                integ_acc, last_err;

    t_out_word drive_queue[$];

    // (a*b) >> sh, truncated toward zero, saturated to +-lim
    function automatic longint scaled_product(longint a, longint b, int sh, longint lim);
        logic [127:0] prod;
        logic [63:0]  ma, mb;
        bit           neg;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = ({64'b0, ma} * {64'b0, mb}) >> sh;
        if (prod > 128'(lim))
            prod = 128'(lim);
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    // (num << FRACTION_BITS) / den, truncated, saturated to +-SAT_MAX
    function automatic longint rate_quotient(longint num, logic [63:0] den);
        logic [127:0] q;
        logic [63:0]  m;
        m = (num < 0) ? -num : num;
        q = ({64'b0, m} << FRACTION_BITS) / {64'b0, den};
        if (q > 128'(SAT_MAX))
            q = 128'(SAT_MAX);
        return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // one compute word: update state and return the expected output word
    function automatic t_out_word pid_update(longint err, logic [DATA_WIDTH-1:0] stamp);
        logic [DATA_WIDTH-1:0] dt;
        longint    inc, slope, p_term, i_term, d_term, mp, md, lim_d, u;
        t_out_word w;
        dt         = stamp - last_stamp;
        last_stamp = stamp;
        inc        = scaled_product(err + last_err, longint'({32'b0, dt}),
                                    FRACTION_BITS + 1, INC_MAX);
        integ_acc  = clip(integ_acc + inc, integ_lim);
        w.zero_interval = (dt == 0);
        slope      = (dt == 0) ? 0 : rate_quotient(err - last_err, {32'b0, dt});
        last_err   = err;
        p_term     = scaled_product(kp, err, FRACTION_BITS, SAT_MAX);
        i_term     = scaled_product(ki, integ_acc, FRACTION_BITS, SAT_MAX);
        d_term     = scaled_product(kd, slope, FRACTION_BITS, SAT_MAX);
        if (abs_lim) begin
            mp     = (p_term < 0) ? -p_term : p_term;
            md     = (d_term < 0) ? -d_term : d_term;
            lim_d  = (mp < md) ? mp : md;
            d_term = (slope < 0) ? -lim_d : lim_d;
        end
        u       = clip(p_term + i_term + d_term, out_lim);
        w.drive = u[DATA_WIDTH-1:0];
        return w;
    endfunction

    // watch register writes, input words and output words
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            kp = 65536; ki = 65536; kd = 65536;
            integ_lim = SAT_MAX; out_lim = SAT_MAX; abs_lim = 0;
            last_stamp = '0; integ_acc = 0; last_err = 0;
            drive_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                case (t_reg_idx'(i_paddr[ADDR_W-1:2]))
                    REG_PROP_GAIN:    kp = longint'(signed'(i_pwdata));
                    REG_INTEG_GAIN:   ki = longint'(signed'(i_pwdata));
                    REG_DERIV_GAIN:   kd = longint'(signed'(i_pwdata));
                    REG_INTEG_LIMIT:  integ_lim = longint'({33'b0, i_pwdata[30:0]});
                    REG_OUTPUT_LIMIT: out_lim = longint'({33'b0, i_pwdata[30:0]});
                    REG_ABS_MODE:     abs_lim = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_word.operation == OP_RESTART) begin
                    last_stamp = i_in_word.timestamp;
                    integ_acc  = 0;
                    last_err   = 0;
                end else begin
                    drive_queue.push_back(pid_update(longint'(i_in_word.error_value),
                                                     i_in_word.timestamp));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (drive_queue.size() == 0) begin
                    $error("output word with no expectation: drive %0d", i_out_word.drive);
                    o_fail_count++;
                end else begin
                    exp_w = drive_queue.pop_front();
                    if (i_out_word.drive !== exp_w.drive) begin
                        $error("drive: expected %0d, got %0d", exp_w.drive, i_out_word.drive);
                        o_fail_count++;
                    end
                    if (i_out_word.zero_interval !== exp_w.zero_interval) begin
                        $error("zero_interval: expected %0b, got %0b",
                               exp_w.zero_interval, i_out_word.zero_interval);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = drive_queue.size();
    end

endmodule

// ===== sim/tb_pid_trapezoid_clamped_core.sv =====
// Testbench top: stimulus, register setup and verdict for the clamped trapezoid PID core.
`timescale 1ns / 1ps
module tb_pid_trapezoid_clamped_core;
    import pidtc_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_word          in_word;
    logic              out_valid;
    logic              out_ready;
    t_out_word         out_word;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata, prdata;
    logic              pready;
    int                fail_count, pending;
    int                tx_idle_pct, rx_idle_pct;
    logic [31:0]       cur_stamp;

    pid_trapezoid_clamped_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pidtc_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_word(out_word),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge i_clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    // run limit
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // APB write: setup cycle, then access cycle
    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_W'(idx) << 2;
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // present one word and hold it until accepted; entered at a falling edge
    task automatic send_word(logic op, logic [31:0] err, logic [31:0] stamp);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_word.operation   = op;
        in_word.error_value = err;
        in_word.timestamp   = stamp;
        in_valid            = 1'b1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
        cur_stamp = stamp;
    endtask

    // wait until every result is back and the core has gone quiet
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_error();
        case ($urandom_range(3))
            0:       return $urandom;
            1, 2:    return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_stamp(logic [31:0] prev);
        case ($urandom_range(9))
            7:       return prev;
            8:       return $urandom;
            9:       return prev - 32'($urandom_range(1, 1 << 16));
            default: return prev + 32'($urandom_range(1, 1 << 17));
        endcase
    endfunction

    function automatic logic [31:0] small_gain();
        return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 14;
        rx_idle_pct = 62;
        cur_stamp   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int phase = 0; phase < 5; phase++) begin
            drain();
            if (phase == 2) begin
                tx_idle_pct = 62;
                rx_idle_pct = 14;
            end else if (phase == 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // register setting for this phase
            case (phase)
                0: begin
                    reg_write(REG_PROP_GAIN, 32'h0001_0000);
                    reg_write(REG_INTEG_GAIN, 32'h0000_8000);
                    reg_write(REG_DERIV_GAIN, 32'h0000_4000);
                    reg_write(REG_INTEG_LIMIT, 32'h000A_0000);
                    reg_write(REG_OUTPUT_LIMIT, 32'h7FFF_FFFF);
                    reg_write(REG_ABS_MODE, 32'd0);
                end
                1: begin
                    reg_write(REG_PROP_GAIN, 32'h8000_0000);
                    reg_write(REG_INTEG_GAIN, 32'h7FFF_FFFF);
                    reg_write(REG_DERIV_GAIN, $urandom);
                    reg_write(REG_INTEG_LIMIT, 32'd0);
                    reg_write(REG_ABS_MODE, 32'd1);
                end
                4: begin
                    reg_write(REG_PROP_GAIN, 32'h7FFF_FFFF);
                    reg_write(REG_DERIV_GAIN, 32'h8000_0000);
                    reg_write(REG_INTEG_LIMIT, 32'h7FFF_FFFF);
                    reg_write(REG_OUTPUT_LIMIT, 32'd0);
                end
                default: begin
                    reg_write(REG_PROP_GAIN, small_gain());
                    reg_write(REG_INTEG_GAIN, small_gain());
                    reg_write(REG_DERIV_GAIN, small_gain());
                    reg_write(REG_INTEG_LIMIT, $urandom_range(0, 1 << 22));
                    reg_write(REG_OUTPUT_LIMIT, $urandom);
                    reg_write(REG_ABS_MODE, $urandom_range(1));
                end
            endcase

            if (phase == 0) begin
                // extremes, zero interval, wrapped time, ignored restart error
                send_word(OP_RESTART, 32'h0, 32'h0001_0000);
                send_word(OP_COMPUTE, 32'h7FFF_FFFF, 32'h0002_0000);
                send_word(OP_COMPUTE, 32'h8000_0000, 32'h0003_0000);
                send_word(OP_COMPUTE, 32'h8000_0000, 32'h0003_0000);
                send_word(OP_COMPUTE, 32'h0, 32'h0000_0100);
                send_word(OP_RESTART, 32'hDEAD_BEEF, 32'h0000_0200);
                send_word(OP_COMPUTE, 32'h1, 32'h0000_0201);
                send_word(OP_COMPUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                send_word(OP_RESTART, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
                send_word(OP_COMPUTE, 32'h0001_0000, 32'h0000_0010);
                send_word(OP_COMPUTE, 32'h0001_0000, 32'h0000_0010);
                send_word(OP_COMPUTE, 32'h8000_0000, 32'h0000_0000);
                send_word(OP_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000);
                drain();
                reg_write(REG_ABS_MODE, 32'd1);
                send_word(OP_COMPUTE, 32'h0010_0000, 32'h8000_4000);
                send_word(OP_COMPUTE, 32'hFFF0_0000, 32'h8000_4001);
                send_word(OP_COMPUTE, 32'h0000_0000, 32'h8000_4001);
            end

            // random words: mostly steady control traffic, some restarts and jumps
            for (int n = 0; n < 160; n++) begin
                if ($urandom_range(99) < 6)
                    send_word(OP_RESTART, $urandom, rand_stamp(cur_stamp));
                else
                    send_word(OP_COMPUTE, rand_error(), rand_stamp(cur_stamp));
            end
        end

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
